// ----- hdl/ecif_pkg.sv -----
package ecif_pkg;

    // Widest address fields over the whole parameter range.
    localparam int RF_AW_MAX  = 15;
    localparam int TBL_AW_MAX = 18;

    // Host protocol codes.
    localparam logic [7:0]  CMD_REG_ACCESS = 8'h88;
    localparam logic [15:0] CMD_WRITE_FLAG = 16'h8000;
    localparam logic [7:0]  ID_CHIP_HIGH   = 8'h20;
    localparam logic [7:0]  ID_CHIP_LOW    = 8'h21;
    localparam logic [7:0]  ID_UNKNOWN     = 8'hff;
    localparam logic [15:0] CHIP_ID_RESET  = 16'h8528;

    // Table window register ranges.
    localparam logic [14:0] WIN_LOW_FIRST  = 15'h056;
    localparam logic [14:0] WIN_LOW_LAST   = 15'h05e;
    localparam logic [14:0] WIN_HIGH_FIRST = 15'h060;
    localparam logic [14:0] WIN_HIGH_LAST  = 15'h062;

    // LED set and clear registers.
    localparam logic [14:0] LED_LOCATE_SET  = 15'h158;
    localparam logic [14:0] LED_LOCATE_CLR  = 15'h159;
    localparam logic [14:0] LED_PRESENT_SET = 15'h15a;
    localparam logic [14:0] LED_PRESENT_CLR = 15'h15b;
    localparam logic [14:0] LED_ERROR_SET   = 15'h15c;
    localparam logic [14:0] LED_ERROR_CLR   = 15'h15d;
    localparam logic [14:0] LED_ACTIVE_SET  = 15'h15f;
    localparam logic [14:0] LED_ACTIVE_CLR  = 15'h157;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_LOAD_RF,
        KIND_LOAD_TBL
    } t_kind;

    typedef enum logic [1:0] {
        PORT_ID_INDEX,
        PORT_ID_DATA,
        PORT_CMD,
        PORT_DATA
    } t_port;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR_HIGH,
        PH_ADDR_LOW,
        PH_WRITE
    } t_phase;

    // Where the output byte currently lives.
    typedef enum logic [1:0] {
        OB_HELD,
        OB_RF,
        OB_TBL
    } t_ob_src;

    typedef enum logic [1:0] {
        ROLE_HIGH,
        ROLE_LOW,
        ROLE_DATA
    } t_role;

    typedef struct packed {
        logic       hit;
        logic [1:0] win;
        t_role      role;
    } t_win;

    // Memory requests from the controller to the storage.
    typedef struct packed {
        logic                  rf_we;
        logic [RF_AW_MAX-1:0]  rf_waddr;
        logic [7:0]            rf_wdata;
        logic                  rf_re;
        logic [RF_AW_MAX-1:0]  rf_raddr;
        logic                  tbl_we;
        logic [TBL_AW_MAX-1:0] tbl_waddr;
        logic [7:0]            tbl_wdata;
        logic                  tbl_re;
        logic [TBL_AW_MAX-1:0] tbl_raddr;
    } t_mem_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [31:0] present;
        logic [31:0] active;
        logic [31:0] error;
        logic [31:0] locate;
    } t_result;

    // Decode a register address into table window and role.
    function automatic t_win win_decode(input logic [14:0] reg_addr);
        t_win        w;
        logic [14:0] d;
        w = '{hit: 1'b0, win: 2'd0, role: ROLE_HIGH};
        d = '0;
        if (reg_addr >= WIN_LOW_FIRST && reg_addr <= WIN_LOW_LAST) begin
            d     = reg_addr - WIN_LOW_FIRST;
            w.hit = 1'b1;
            case (d[3:0])
                4'd0: begin w.win = 2'd0; w.role = ROLE_HIGH; end
                4'd1: begin w.win = 2'd0; w.role = ROLE_LOW;  end
                4'd2: begin w.win = 2'd0; w.role = ROLE_DATA; end
                4'd3: begin w.win = 2'd1; w.role = ROLE_HIGH; end
                4'd4: begin w.win = 2'd1; w.role = ROLE_LOW;  end
                4'd5: begin w.win = 2'd1; w.role = ROLE_DATA; end
                4'd6: begin w.win = 2'd2; w.role = ROLE_HIGH; end
                4'd7: begin w.win = 2'd2; w.role = ROLE_LOW;  end
                4'd8: begin w.win = 2'd2; w.role = ROLE_DATA; end
                default: w.hit = 1'b0;
            endcase
        end else if (reg_addr >= WIN_HIGH_FIRST && reg_addr <= WIN_HIGH_LAST) begin
            d     = reg_addr - WIN_HIGH_FIRST;
            w.hit = 1'b1;
            w.win = 2'd3;
            case (d[1:0])
                2'd0:    w.role = ROLE_HIGH;
                2'd1:    w.role = ROLE_LOW;
                default: w.role = ROLE_DATA;
            endcase
        end
        return w;
    endfunction

endpackage

// ----- hdl/ecif_ram.sv -----
module ecif_ram
    import ecif_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ecif_ctrl.sv -----
module ecif_ctrl
    import ecif_pkg::*;
#(
    parameter int REGISTER_FILE_BYTES = 1792,
    parameter int TABLE_BYTES         = 512,
    parameter int DISK_COUNT          = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_kind       i_kind,
    input  t_port       i_port,
    input  logic [10:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_chip_id,
    input  logic [7:0]  i_rf_rdata,
    input  logic [7:0]  i_tbl_rdata,
    output t_mem_req    o_mem_req,
    output t_result     o_result
);

    localparam int TBL_DEPTH = 4 * TABLE_BYTES;

    // Architectural state.
    logic [7:0]  r_id_index, n_id_index;
    t_phase      r_phase, n_phase;
    logic        r_output_full, n_output_full;
    logic [7:0]  r_output_byte, n_output_byte;
    t_ob_src     r_ob_src, n_ob_src;
    logic [15:0] r_cmd_word, n_cmd_word;
    logic [15:0] r_offsets [4];
    logic [15:0] n_offsets [4];
    logic [31:0] r_present, n_present;
    logic [31:0] r_active, n_active;
    logic [31:0] r_error, n_error;
    logic [31:0] r_locate, n_locate;

    // Decode helpers.
    logic [7:0]  ob_eff;
    logic [15:0] word;
    logic [14:0] acc_reg;
    t_win        win;
    logic [15:0] off;
    logic        reg_ok;
    logic        off_ok;
    logic        disk_ok;
    logic [31:0] tbl_idx;
    logic [31:0] led_bit;
    logic [7:0]  rd;
    t_mem_req    req;

    // The output byte may still sit in a memory read register.
    always_comb begin
        case (r_ob_src)
            OB_RF:   ob_eff = i_rf_rdata;
            OB_TBL:  ob_eff = i_tbl_rdata;
            OB_HELD: ob_eff = r_output_byte;
            default: ob_eff = r_output_byte;
        endcase
    end

    // Register targeted by the current data byte.
    assign word    = r_cmd_word | {8'h00, i_data_byte};
    assign acc_reg = (r_phase == PH_WRITE) ? r_cmd_word[14:0] : word[14:0];
    assign win     = win_decode(acc_reg);
    assign off     = r_offsets[win.win];
    assign reg_ok  = 32'(acc_reg) < 32'(REGISTER_FILE_BYTES);
    assign off_ok  = 32'(off) < 32'(TABLE_BYTES);
    assign tbl_idx = 32'(win.win) * 32'(TABLE_BYTES) + 32'(off);
    assign disk_ok = 32'(i_data_byte) < 32'(DISK_COUNT);
    assign led_bit = 32'(1) << i_data_byte[4:0];

    // Next state, memory requests and the result.
    always_comb begin
        n_id_index    = r_id_index;
        n_phase       = r_phase;
        n_output_full = r_output_full;
        n_output_byte = r_output_byte;
        n_ob_src      = r_ob_src;
        n_cmd_word    = r_cmd_word;
        n_offsets     = r_offsets;
        n_present     = r_present;
        n_active      = r_active;
        n_error       = r_error;
        n_locate      = r_locate;
        rd            = '0;
        req           = '0;
        if (i_fire) begin
            case (i_kind)
                KIND_READ: begin
                    case (i_port)
                        PORT_ID_INDEX: rd = r_id_index;
                        PORT_ID_DATA: begin
                            if (r_id_index == ID_CHIP_HIGH) begin
                                rd = i_chip_id[15:8];
                            end else if (r_id_index == ID_CHIP_LOW) begin
                                rd = i_chip_id[7:0];
                            end else begin
                                rd = ID_UNKNOWN;
                            end
                        end
                        PORT_CMD: rd = {7'd0, r_output_full};
                        PORT_DATA: begin
                            rd            = ob_eff;
                            n_output_byte = '0;
                            n_ob_src      = OB_HELD;
                            n_output_full = 1'b0;
                        end
                        default: rd = '0;
                    endcase
                end
                KIND_WRITE: begin
                    case (i_port)
                        PORT_ID_INDEX: n_id_index = i_data_byte;
                        PORT_CMD: begin
                            if (i_data_byte == CMD_REG_ACCESS) begin
                                n_phase = PH_ADDR_HIGH;
                            end
                        end
                        PORT_DATA: begin
                            case (r_phase)
                                PH_ADDR_HIGH: begin
                                    n_cmd_word = {i_data_byte, 8'h00};
                                    n_phase    = PH_ADDR_LOW;
                                end
                                PH_ADDR_LOW: begin
                                    if ((word & CMD_WRITE_FLAG) != '0) begin
                                        n_cmd_word = word & ~CMD_WRITE_FLAG;
                                        n_phase    = PH_WRITE;
                                    end else begin
                                        n_cmd_word    = word;
                                        n_output_full = 1'b1;
                                        n_phase       = PH_IDLE;
                                        n_output_byte = '0;
                                        n_ob_src      = OB_HELD;
                                        if (reg_ok) begin
                                            if (win.hit && win.role == ROLE_DATA) begin
                                                if (off_ok) begin
                                                    req.tbl_re    = 1'b1;
                                                    req.tbl_raddr = tbl_idx[TBL_AW_MAX-1:0];
                                                    n_ob_src      = OB_TBL;
                                                end
                                            end else begin
                                                req.rf_re    = 1'b1;
                                                req.rf_raddr = acc_reg;
                                                n_ob_src     = OB_RF;
                                            end
                                        end
                                    end
                                end
                                PH_WRITE: begin
                                    n_phase = PH_IDLE;
                                    if (reg_ok) begin
                                        if (win.hit && win.role == ROLE_HIGH) begin
                                            n_offsets[win.win] = {i_data_byte, 8'h00};
                                        end else if (win.hit && win.role == ROLE_LOW) begin
                                            n_offsets[win.win] = off | {8'h00, i_data_byte};
                                        end
                                        req.rf_we    = 1'b1;
                                        req.rf_waddr = acc_reg;
                                        req.rf_wdata = i_data_byte;
                                        if (disk_ok) begin
                                            case (acc_reg)
                                                LED_PRESENT_SET: n_present = r_present | led_bit;
                                                LED_PRESENT_CLR: n_present = r_present & ~led_bit;
                                                LED_ERROR_SET:   n_error   = r_error | led_bit;
                                                LED_ERROR_CLR:   n_error   = r_error & ~led_bit;
                                                LED_LOCATE_SET:  n_locate  = r_locate | led_bit;
                                                LED_LOCATE_CLR:  n_locate  = r_locate & ~led_bit;
                                                LED_ACTIVE_SET:  n_active  = r_active | led_bit;
                                                LED_ACTIVE_CLR:  n_active  = r_active & ~led_bit;
                                                default: ;
                                            endcase
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                KIND_LOAD_RF: begin
                    if (32'(i_address) < 32'(REGISTER_FILE_BYTES)) begin
                        req.rf_we    = 1'b1;
                        req.rf_waddr = RF_AW_MAX'(i_address);
                        req.rf_wdata = i_data_byte;
                    end
                end
                KIND_LOAD_TBL: begin
                    if (32'(i_address) < 32'(TBL_DEPTH)) begin
                        req.tbl_we    = 1'b1;
                        req.tbl_waddr = TBL_AW_MAX'(i_address);
                        req.tbl_wdata = i_data_byte;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_index    <= '0;
            r_phase       <= PH_IDLE;
            r_output_full <= 1'b0;
            r_output_byte <= '0;
            r_ob_src      <= OB_HELD;
            r_cmd_word    <= '0;
            r_offsets     <= '{default: '0};
            r_present     <= '0;
            r_active      <= '0;
            r_error       <= '0;
            r_locate      <= '0;
        end else begin
            r_id_index    <= n_id_index;
            r_phase       <= n_phase;
            r_output_full <= n_output_full;
            r_output_byte <= n_output_byte;
            r_ob_src      <= n_ob_src;
            r_cmd_word    <= n_cmd_word;
            r_offsets     <= n_offsets;
            r_present     <= n_present;
            r_active      <= n_active;
            r_error       <= n_error;
            r_locate      <= n_locate;
        end
    end

    assign o_mem_req          = req;
    assign o_result.read_data = rd;
    assign o_result.present   = n_present;
    assign o_result.active    = n_active;
    assign o_result.error     = n_error;
    assign o_result.locate    = n_locate;

endmodule

// ----- hdl/embedded_controller_host_interface_unit.sv -----
// Channel   Direction  Handshake                         Contents
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  one host bus access or load
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  read byte and four LED masks
// cfg       in         i_cfg_valid / o_cfg_ready          chip identification word
//
// One transaction is accepted per cycle while the result side does not stall and
// no clearing pass runs; each gives one result, through the input register and then
// the result register. After reset a clearing pass zeroes both stores; no access
// is accepted until it ends.
// A stalled result holds in the result register while one more access waits
// in the input register.
module embedded_controller_host_interface_unit
    import ecif_pkg::*;
#(
    parameter int REGISTER_FILE_BYTES = 1792,
    parameter int TABLE_BYTES         = 512,
    parameter int DISK_COUNT          = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,  // address[10:0], data byte[18:11], zero pad
    input  logic [3:0]   i_s_axis_tuser,  // kind[1:0], port[3:2]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // read_data[7:0], disk_present_mask[39:8], disk_active_mask[71:40],
    // disk_error_mask[103:72], disk_locate_mask[135:104]
    output logic [135:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);

    localparam int TBL_DEPTH = 4 * TABLE_BYTES;
    localparam int CLR_DEPTH = (REGISTER_FILE_BYTES > TBL_DEPTH) ?
                               REGISTER_FILE_BYTES : TBL_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int RF_AW     = $clog2(REGISTER_FILE_BYTES);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic              r_clr_busy;
    logic [CLR_AW-1:0] r_clr_cnt;
    logic              clr_rf_we;
    logic              clr_tbl_we;

    logic        r_in_valid;
    t_kind       r_in_kind;
    t_port       r_in_port;
    logic [10:0] r_in_addr;
    logic [7:0]  r_in_wdata;
    logic        w_fire;

    logic         r_out_valid;
    logic [135:0] r_out_data;

    logic [15:0] r_chip_id;

    t_mem_req    w_req;
    t_result     w_result;
    logic [7:0]  rf_rdata;
    logic [7:0]  tbl_rdata;

    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr;
    logic [7:0]        rf_wdata;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [7:0]        tbl_wdata;

    // Clearing pass over both stores after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_AW'(CLR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign clr_rf_we  = r_clr_busy && (32'(r_clr_cnt) < 32'(REGISTER_FILE_BYTES));
    assign clr_tbl_we = r_clr_busy && (32'(r_clr_cnt) < 32'(TBL_DEPTH));

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_id <= CHIP_ID_RESET;
        end else if (i_cfg_valid) begin
            r_chip_id <= i_cfg_data;
        end
    end

    // Input register; the item moves on when the result register is free.
    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_clr_busy && (!r_in_valid || w_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind  <= t_kind'(i_s_axis_tuser[1:0]);
            r_in_port  <= t_port'(i_s_axis_tuser[3:2]);
            r_in_addr  <= i_s_axis_tdata[10:0];
            r_in_wdata <= i_s_axis_tdata[18:11];
        end
    end

    // Host protocol and LED state.
    ecif_ctrl #(
        .REGISTER_FILE_BYTES (REGISTER_FILE_BYTES),
        .TABLE_BYTES         (TABLE_BYTES),
        .DISK_COUNT          (DISK_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_kind       (r_in_kind),
        .i_port       (r_in_port),
        .i_address    (r_in_addr),
        .i_data_byte  (r_in_wdata),
        .i_chip_id    (r_chip_id),
        .i_rf_rdata   (rf_rdata),
        .i_tbl_rdata  (tbl_rdata),
        .o_mem_req    (w_req),
        .o_result     (w_result)
    );

    // Write ports: the clearing pass or the controller.
    assign rf_we     = clr_rf_we || w_req.rf_we;
    assign rf_waddr  = r_clr_busy ? r_clr_cnt[RF_AW-1:0] : w_req.rf_waddr[RF_AW-1:0];
    assign rf_wdata  = r_clr_busy ? 8'h00 : w_req.rf_wdata;
    assign tbl_we    = clr_tbl_we || w_req.tbl_we;
    assign tbl_waddr = r_clr_busy ? r_clr_cnt[TBL_AW-1:0] : w_req.tbl_waddr[TBL_AW-1:0];
    assign tbl_wdata = r_clr_busy ? 8'h00 : w_req.tbl_wdata;

    ecif_ram #(
        .DEPTH (REGISTER_FILE_BYTES),
        .WIDTH (8)
    ) u_rf_ram (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (w_req.rf_re),
        .i_raddr (w_req.rf_raddr[RF_AW-1:0]),
        .o_rdata (rf_rdata)
    );

    ecif_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (8)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (w_req.tbl_re),
        .i_raddr (w_req.tbl_raddr[TBL_AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {w_result.locate, w_result.error, w_result.active,
                           w_result.present, w_result.read_data};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // No item may reach the controller before the stores are cleared.
    a_no_item_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_in_valid
    ) else $error("item held in input register during clearing pass");

    // Every processed item leaves a result behind.
    a_fire_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid
    ) else $error("processed item left no result");

    // An item touches at most one memory port.
    a_one_mem_op: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_req.rf_we, w_req.rf_re, w_req.tbl_we, w_req.tbl_re}) <= 1
    ) else $error("more than one memory operation for one item");

    // The clearing pass owns the write ports alone.
    a_clear_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(w_req.rf_we || w_req.tbl_we || w_req.rf_re || w_req.tbl_re)
    ) else $error("memory request during clearing pass");

endmodule
